FILE: src/hdlcdr_pkg.sv
// Shared types and constants of the HDLC deframer with pipe slot ring.
`default_nettype none

package hdlcdr_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE        = 3'd0,
		REG_END_BYTE          = 3'd1,
		REG_ESCAPE_BYTE       = 3'd2,
		REG_UNSTUFF_MASK      = 3'd3,
		REG_PIPE_TYPE_ID      = 3'd4,
		REG_SLOTS_IN_USE      = 3'd5,
		REG_PACKETS_PER_BLOCK = 3'd6
	} reg_idx_t;

	// Input opcodes.
	localparam logic OP_BYTE     = 1'b0;
	localparam logic OP_RING_CLR = 1'b1;

	// Result kinds.
	localparam logic RK_DATA = 1'b0;
	localparam logic RK_END  = 1'b1;

	// Frame types as reported.
	typedef enum logic [1:0] {
		FT_CTL  = 2'd0,
		FT_PIPE = 2'd1,
		FT_NONE = 2'd2
	} frame_type_t;

	// Commands passed from the front end to the back end.
	typedef enum logic [1:0] {
		CMD_RING_CLR = 2'd0,
		CMD_OPEN     = 2'd1,
		CMD_STORE    = 2'd2,
		CMD_END      = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  data;
		frame_type_t ftype;
	} cmd_t;

	// Input item.
	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic        result_kind;
		logic [7:0]  data_byte;
		logic [9:0]  byte_offset;
		logic [1:0]  frame_type;
		logic [3:0]  slot_index;
		logic [10:0] frame_length;
		logic        overflow;
		logic        block_done;
		logic [3:0]  block_start_slot;
	} out_item_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] escape_byte;
		logic [7:0] unstuff_mask;
		logic [7:0] pipe_type_id;
		logic [4:0] slots_in_use;
		logic [7:0] packets_per_block;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_byte:        8'h7E,
		end_byte:          8'h7D,
		escape_byte:       8'd124,
		unstuff_mask:      8'd32,
		pipe_type_id:      8'd0,
		slots_in_use:      5'd16,
		packets_per_block: 8'd4
	};

endpackage

`default_nettype wire

FILE: src/hdlc_deframer_pipe_ring_core.sv
// Top level of the HDLC byte deframer feeding a ring of pipe slots.
//
// Usage: received bytes enter on the in channel (valid/ready) as in_item, with
// opcode 0; opcode 1 clears the slot ring head, block start and packet count.
// Results leave on the out channel (valid/ready) as out_item: a stored data
// byte with its offset, or a frame end report with type, length, overflow,
// ring slot and block completion. Many items give no result at all.
// One item is accepted per cycle while the queue is not full. The front end
// classifies it in the cycle it is accepted and writes a command into a
// two-entry queue; the back end takes one command per cycle while the output
// register is free or being read, and registers the result it causes there.
// When the receiver stalls, the output register holds its item and the queue
// absorbs up to two more commands before in ready drops; no item is lost.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data in a
// single cycle and must only change while the block is idle.
// Reset (arst_n low) restores default register values, closes any frame,
// clears the ring state, empties the queue and drops out_valid.
`default_nettype none

module hdlc_deframer_pipe_ring_core
	import hdlcdr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 1024,
	parameter int PIPE_SLOTS      = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_item
);

	localparam int CMD_W = $bits(cmd_t);

	cfg_t       cfg_q;
	logic       take;
	logic       push;
	cmd_t       front_cmd;
	logic       q_full, q_valid, q_pop;
	logic [CMD_W-1:0] q_rdata;
	cmd_t       back_cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_START_BYTE:        cfg_q.start_byte        <= cfg_data;
				REG_END_BYTE:          cfg_q.end_byte          <= cfg_data;
				REG_ESCAPE_BYTE:       cfg_q.escape_byte       <= cfg_data;
				REG_UNSTUFF_MASK:      cfg_q.unstuff_mask      <= cfg_data;
				REG_PIPE_TYPE_ID:      cfg_q.pipe_type_id      <= cfg_data;
				REG_SLOTS_IN_USE:      cfg_q.slots_in_use      <= cfg_data[4:0];
				REG_PACKETS_PER_BLOCK: cfg_q.packets_per_block <= cfg_data;
				default:               cfg_q                   <= cfg_q;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign back_cmd = cmd_t'(q_rdata);

	hdlcdr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.item   (in_item),
		.push   (push),
		.cmd    (front_cmd)
	);

	hdlcdr_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (q_rdata)
	);

	hdlcdr_back #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.PIPE_SLOTS      (PIPE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

FILE: src/hdlcdr_front.sv
// Front end: tracks framing state per received byte and emits commands.
`default_nettype none

module hdlcdr_front
	import hdlcdr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     take,
	input  wire in_item_t item,
	output logic          push,
	output cmd_t          cmd
);

	logic        in_frame_q, in_frame_d;
	logic        esc_q, esc_d;
	frame_type_t type_q, type_d;

	// Framing state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			type_q     <= FT_NONE;
		end else begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			type_q     <= type_d;
		end
	end

	// Classify the item in the fixed check order.
	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		type_d     = type_q;
		push       = 1'b0;
		cmd.op     = CMD_STORE;
		cmd.data   = item.rx_byte;
		cmd.ftype  = type_q;
		if (take) begin
			priority if (item.opcode == OP_RING_CLR) begin
				push   = 1'b1;
				cmd.op = CMD_RING_CLR;
			end else if (in_frame_q && item.rx_byte == cfg.end_byte) begin
				push       = 1'b1;
				cmd.op     = CMD_END;
				in_frame_d = 1'b0;
				esc_d      = 1'b0;
			end else if (item.rx_byte == cfg.start_byte) begin
				push       = 1'b1;
				cmd.op     = CMD_OPEN;
				in_frame_d = 1'b1;
				esc_d      = 1'b0;
				type_d     = FT_NONE;
			end else if (!in_frame_q) begin
				push = 1'b0;
			end else if (type_q == FT_NONE) begin
				// The type byte is stored raw.
				type_d    = (item.rx_byte == cfg.pipe_type_id) ? FT_PIPE : FT_CTL;
				push      = 1'b1;
				cmd.ftype = type_d;
			end else if (item.rx_byte == cfg.escape_byte) begin
				esc_d = 1'b1;
			end else if (esc_q) begin
				esc_d    = 1'b0;
				push     = 1'b1;
				cmd.data = item.rx_byte ^ cfg.unstuff_mask;
			end else begin
				push = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/hdlcdr_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module hdlcdr_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("command queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("command queue read while empty");

endmodule

`default_nettype wire

FILE: src/hdlcdr_back.sv
// Back end: frame byte count, slot ring, block counting and result register.
`default_nettype none

module hdlcdr_back
	import hdlcdr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 1024,
	parameter int PIPE_SLOTS      = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_item_t  out_item
);

	localparam int         CW     = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [4:0] SLOTS5 = 5'(PIPE_SLOTS);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [3:0]    head_q, bstart_q;
	logic [7:0]    pcount_q;
	logic          out_valid_q;
	out_item_t     out_item_q;

	logic [10:0]   cnt_ext;
	logic          cnt_full;
	logic [4:0]    limit, head_inc;
	logic [3:0]    head_next;
	logic [7:0]    ppb, pcount_inc;
	logic          blk_done;
	logic          produce;
	out_item_t     res;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cmd_pop   = cmd_valid && (!out_valid_q || out_ready);

	// Frame byte count checks, and ring and block arithmetic for a pipe frame end.
	always_comb begin
		cnt_ext    = 11'(cnt_q);
		cnt_full   = (cnt_q >= CW'(MAX_FRAME_BYTES));
		if (cfg.slots_in_use == 5'd0) begin
			limit = 5'd1;
		end else if (cfg.slots_in_use > SLOTS5) begin
			limit = SLOTS5;
		end else begin
			limit = cfg.slots_in_use;
		end
		head_inc   = {1'b0, head_q} + 5'd1;
		head_next  = (head_inc >= limit) ? 4'd0 : head_inc[3:0];
		ppb        = (cfg.packets_per_block == 8'd0) ? 8'd1 : cfg.packets_per_block;
		pcount_inc = pcount_q + 8'd1;
		blk_done   = (pcount_inc >= ppb);
	end

	// Build the result for the command at the head of the queue.
	always_comb begin
		res         = '0;
		produce     = 1'b0;
		res.frame_type = cmd.ftype;
		unique case (cmd.op)
			CMD_STORE: begin
				produce         = !cnt_full;
				res.result_kind = RK_DATA;
				res.data_byte   = cmd.data;
				res.byte_offset = cnt_ext[9:0];
				res.slot_index  = (cmd.ftype == FT_PIPE) ? head_q : 4'd0;
			end
			CMD_END: begin
				produce          = 1'b1;
				res.result_kind  = RK_END;
				res.frame_length = cnt_ext;
				res.overflow     = ovf_q;
				if (cmd.ftype == FT_PIPE) begin
					res.slot_index = head_q;
					if (blk_done) begin
						res.block_done       = 1'b1;
						res.block_start_slot = bstart_q;
					end
				end
			end
			CMD_OPEN, CMD_RING_CLR: begin
				produce = 1'b0;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
	end

	// Frame and ring state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			head_q   <= '0;
			bstart_q <= '0;
			pcount_q <= '0;
		end else if (cmd_pop) begin
			unique case (cmd.op)
				CMD_RING_CLR: begin
					head_q   <= '0;
					bstart_q <= '0;
					pcount_q <= '0;
				end
				CMD_OPEN: begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				CMD_STORE: begin
					if (cnt_full) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				CMD_END: begin
					if (cmd.ftype == FT_PIPE) begin
						head_q <= head_next;
						if (blk_done) begin
							pcount_q <= '0;
							bstart_q <= head_next;
						end else begin
							pcount_q <= pcount_inc;
						end
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Output register; holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= produce;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && produce) begin
			out_item_q <= res;
		end
	end

	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.result_kind == RK_DATA)
			|-> (11'(out_item_q.byte_offset) < 11'(MAX_FRAME_BYTES)))
		else $error("data item offset beyond frame buffer");

	a_done_only_pipe_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.block_done)
			|-> (out_item_q.result_kind == RK_END && out_item_q.frame_type == FT_PIPE))
		else $error("block done reported outside a pipe frame end");

	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < SLOTS5)
		else $error("ring head outside the slot ring");

endmodule

`default_nettype wire
